// ===== rtl/core/mfd_pkg.sv =====
// ----------------------------------------------------------------------------
// mfd_pkg
// shared sizes, codes, controller states and item types of the min-front deque
// ----------------------------------------------------------------------------
package mfd_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned ValueW = 32;
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_READ = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [ValueW-1:0] value;
    logic [PtrW-1:0]          position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [ValueW-1:0] data;
    logic                     data_valid;
    logic [CntW-1:0]          count;
    logic signed [ValueW-1:0] minimum;
  } out_item_t;

endpackage

// ===== rtl/core/min_front_deque.sv =====
// ----------------------------------------------------------------------------
// min_front_deque
// bounded circular store of signed values, held in one synchronous ram,
// with push (front if empty or below the minimum, else back), pop and indexed read
// ----------------------------------------------------------------------------
//
// usage
//   input channel in_valid_i / in_stall_o carries one item: opcode, value,
//   position. output channel out_valid_o / out_stall_i carries one result
//   item per input item: status, data, data_valid, count, minimum.
//   an item moves at a rising edge with valid high and stall low.
// results and intake
//   push, rejected operations, pop of the last element and the unused
//   opcode: result registered at the accepting edge, one item per cycle
//   unless the output stalls. read: one ram read, result registered in
//   the following cycle from S_READ, where no new item is taken.
//   pop leaving n elements (n > 0): the minimum is rescanned through the
//   single ram read port, one element a cycle, and the result registered
//   once the last read is folded in; no new item is taken during the scan.
// reset
//   store empty, minimum zero, no result pending. ram contents are not
//   cleared; only written entries are ever read.
// stall
//   a held result sits in the output register; a new item is taken in the
//   same cycle that result leaves, never while it is stuck.
//
module min_front_deque (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mfd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfd_pkg::out_item_t out_item_o
);
  import mfd_pkg::*;

  // element ram
  logic signed [ValueW-1:0] mem_q [Depth];
  logic                     mem_we;
  logic [PtrW-1:0]          mem_waddr;
  logic signed [ValueW-1:0] mem_wdata;
  logic                     mem_re;
  logic [PtrW-1:0]          mem_raddr;
  logic signed [ValueW-1:0] rd_data_q;

  // control and scan state
  state_e                   state_q, state_d;
  logic [PtrW-1:0]          front_q, front_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic signed [ValueW-1:0] min_q, min_d;
  logic [CntW-1:0]          issue_q, issue_d;
  logic                     rd_pend_q, rd_pend_d;
  logic                     rd_first_q, rd_first_d;
  logic signed [ValueW-1:0] pop_data_q, pop_data_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  out_item_t                out_q, out_d;

  logic                     accept;
  logic                     scan_re;

  // circular index: base + offset, offset always below the depth
  function automatic logic [PtrW-1:0] slot(input logic [PtrW-1:0] base,
                                           input logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(base) + (CntW + 1)'(off);
    if (sum >= (CntW + 1)'(Depth)) begin
      sum = sum - (CntW + 1)'(Depth);
    end
    return sum[PtrW-1:0];
  endfunction

  // ram ports: writes happen only on push in idle, reads only in later
  // cycles or on a read item, so the same entry is never in flight twice
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      front_q     <= '0;
      cnt_q       <= '0;
      min_q       <= '0;
      issue_q     <= '0;
      rd_pend_q   <= 1'b0;
      rd_first_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      cnt_q       <= cnt_d;
      min_q       <= min_d;
      issue_q     <= issue_d;
      rd_pend_q   <= rd_pend_d;
      rd_first_q  <= rd_first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    pop_data_q <= pop_data_d;
  end

  // next state, ram control and result
  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    cnt_d       = cnt_q;
    min_d       = min_q;
    issue_d     = issue_q;
    pop_data_d  = pop_data_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = in_item_i.value;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    in_stall_o  = 1'b1;
    accept      = 1'b0;
    scan_re     = 1'b0;

    case (state_q)
      S_IDLE: begin
        // take an item only when the output register is free or leaving
        in_stall_o = out_valid_q && out_stall_i;
        accept     = in_valid_i && !in_stall_o;
        if (accept) begin
          out_valid_d     = 1'b1;
          out_d.status    = ST_OK;
          out_d.data      = '0;
          out_d.data_valid = 1'b0;
          out_d.count     = cnt_q;
          out_d.minimum   = min_q;
          case (in_item_i.opcode)
            OP_PUSH: begin
              if (cnt_q == CntW'(Depth)) begin
                out_d.status = ST_FULL;
              end else begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + 1'b1;
                if (cnt_q == '0 || $signed(in_item_i.value) < $signed(min_q)) begin
                  // new front; it is the new minimum, no rescan needed
                  front_d   = (front_q == '0) ? PtrW'(Depth - 1) : front_q - 1'b1;
                  mem_waddr = front_d;
                  min_d     = in_item_i.value;
                end else begin
                  // append at the back; minimum unchanged
                  mem_waddr = slot(front_q, cnt_q);
                end
                out_d.count   = cnt_d;
                out_d.minimum = min_d;
              end
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                out_d.status = ST_EMPTY;
              end else begin
                cnt_d = cnt_q - 1'b1;
                if (cnt_q == CntW'(1)) begin
                  // last element gone: store empty
                  front_d       = '0;
                  min_d         = '0;
                  out_d.count   = '0;
                  out_d.minimum = '0;
                end else begin
                  // rescan from the new front before answering
                  front_d     = slot(front_q, CntW'(1));
                  issue_d     = '0;
                  out_valid_d = 1'b0;
                  state_d     = S_SCAN;
                end
              end
            end
            OP_READ: begin
              if (cnt_q == '0) begin
                out_d.status = ST_EMPTY;
              end else if (CntW'(in_item_i.position) >= cnt_q) begin
                out_d.status = ST_RANGE;
              end else begin
                mem_re      = 1'b1;
                mem_raddr   = slot(front_q, CntW'(in_item_i.position));
                out_valid_d = 1'b0;
                state_d     = S_READ;
              end
            end
            default: begin
              // unused opcode: nothing changes
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_d      = 1'b1;
        out_d.status     = ST_OK;
        out_d.data       = rd_data_q;
        out_d.data_valid = 1'b1;
        out_d.count      = cnt_q;
        out_d.minimum    = min_q;
        state_d          = S_IDLE;
      end
      S_SCAN: begin
        // issue one read a cycle, fold the previous read into the minimum
        scan_re   = issue_q < cnt_q;
        mem_re    = scan_re;
        mem_raddr = slot(front_q, issue_q);
        if (scan_re) begin
          issue_d = issue_q + 1'b1;
        end
        if (rd_pend_q) begin
          if (rd_first_q) begin
            min_d      = rd_data_q;
            pop_data_d = rd_data_q;
          end else if ($signed(rd_data_q) < $signed(min_q)) begin
            min_d = rd_data_q;
          end
        end
        if (!scan_re && !rd_pend_q) begin
          out_valid_d      = 1'b1;
          out_d.status     = ST_OK;
          out_d.data       = pop_data_q;
          out_d.data_valid = 1'b1;
          out_d.count      = cnt_q;
          out_d.minimum    = min_q;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    rd_pend_d  = scan_re;
    rd_first_d = scan_re && (issue_q == '0);
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // a push always answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.opcode == OP_PUSH) |=> out_valid_o)
    else $error("push result missing");

  // the element count never goes past the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("element count overflow");

  // the scan never issues past the stored elements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (issue_q <= cnt_q && cnt_q != '0))
    else $error("scan index out of range");

  // an empty store reports zero minimum and no data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.count == '0) |->
      (out_item_o.minimum == '0 && !out_item_o.data_valid))
    else $error("empty store result inconsistent");

endmodule

// ===== verif/tb_min_front_deque.sv =====
// ----------------------------------------------------------------------------
// tb_min_front_deque
// self-checking bench for the min-front deque: a shadow copy of the store
// predicts every result item, directed corner items then random sequences,
// run under four sender and receiver idling phases
// ----------------------------------------------------------------------------
module tb_min_front_deque;
  timeunit 1ns;
  timeprecision 1ps;

  import mfd_pkg::*;

  // the opcode value that the package leaves without a name
  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int         CycleLimit = 400000;
  localparam int         DrainWait  = 24;
  localparam int         NumPhases  = 4;

  logic       clk_i;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall_o;
  in_item_t   in_item     = '0;
  logic       out_valid_o;
  logic       out_stall   = 1'b0;
  out_item_t  out_item_o;

  min_front_deque u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_item_o (out_item_o)
  );

  // items waiting to be driven and results waiting to be seen
  in_item_t   pending_items[$];
  out_item_t  awaited_results[$];

  // shadow copy of the deque
  logic signed [ValueW-1:0] shadow_store [Depth];
  logic [PtrW-1:0]          shadow_front = '0;
  logic [CntW-1:0]          shadow_count = '0;
  logic signed [ValueW-1:0] shadow_min   = '0;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  bit  in_moved       = 1'b0;
  int  errors         = 0;
  int  cycle_count    = 0;
  int  items_taken    = 0;
  int  results_seen   = 0;
  int  peak_fill      = 0;
  int  status_seen [4] = '{0, 0, 0, 0};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic signed [ValueW-1:0] store_minimum();
    logic signed [ValueW-1:0] m;
    logic [PtrW-1:0]          idx;
    if (shadow_count == 0) return '0;
    m = shadow_store[shadow_front];
    for (int k = 1; k < shadow_count; k++) begin
      idx = shadow_front + PtrW'(k);
      if (shadow_store[idx] < m) m = shadow_store[idx];
    end
    return m;
  endfunction

  function automatic void apply_deque_op(input in_item_t item);
    out_item_t       want;
    logic [PtrW-1:0] idx;
    want        = '0;
    want.status = ST_OK;
    case (item.opcode)
      OP_PUSH: begin
        if (shadow_count >= Depth) begin
          want.status = ST_FULL;
        end else begin
          // strictly below the minimum, or empty: goes in at the front
          if (shadow_count == 0 || item.value < shadow_min) begin
            shadow_front               = shadow_front - 1'b1;
            shadow_store[shadow_front] = item.value;
          end else begin
            idx               = shadow_front + shadow_count[PtrW-1:0];
            shadow_store[idx] = item.value;
          end
          shadow_count = shadow_count + 1'b1;
          shadow_min   = store_minimum();
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          want.status = ST_EMPTY;
        end else begin
          shadow_front = shadow_front + 1'b1;
          shadow_count = shadow_count - 1'b1;
          if (shadow_count == 0) begin
            shadow_front = '0;
          end else begin
            want.data       = shadow_store[shadow_front];
            want.data_valid = 1'b1;
          end
          shadow_min = store_minimum();
        end
      end
      OP_READ: begin
        if (shadow_count == 0) begin
          want.status = ST_EMPTY;
        end else if (CntW'(item.position) >= shadow_count) begin
          want.status = ST_RANGE;
        end else begin
          idx             = shadow_front + item.position;
          want.data       = shadow_store[idx];
          want.data_valid = 1'b1;
        end
      end
      default: ;  // unused opcode leaves the store alone
    endcase
    want.count   = shadow_count;
    want.minimum = shadow_min;
    if (shadow_count > peak_fill) peak_fill = shadow_count;
    awaited_results.push_back(want);
  endfunction

  // ------------------------------------------------------------------ checking
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // ----------------------------------------------------------------- stimulus
  function automatic void queue_item(input logic [1:0] op, input logic signed [ValueW-1:0] v,
                                     input logic [PtrW-1:0] pos);
    in_item_t it;
    it.opcode   = op;
    it.value    = v;
    it.position = pos;
    pending_items.push_back(it);
  endfunction

  // extremes and a narrow band near zero, so ties with the minimum are common
  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return {1'b0, {(ValueW-1){1'b1}}};
      1:       return {1'b1, {(ValueW-1){1'b0}}};
      2, 3, 4: return ValueW'(int'($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random_items(input int amount);
    int made;
    int push_pct;
    int run_len;
    int pick;
    made = 0;
    while (made < amount) begin
      // runs leaning to fill, to drain, or balanced, so full and empty both recur
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      run_len = $urandom_range(40, 10);
      for (int i = 0; i < run_len && made < amount; i++) begin
        pick = $urandom_range(99);
        if (pick < push_pct) begin
          queue_item(OP_PUSH, pick_value(), PtrW'($urandom));
        end else begin
          pick = $urandom_range(99);
          if (pick < 50)      queue_item(OP_POP, $urandom, PtrW'($urandom));
          else if (pick < 95) queue_item(OP_READ, $urandom, PtrW'($urandom));
          else                queue_item(OpUnused, $urandom, PtrW'($urandom));
        end
        made++;
      end
    end
  endfunction

  function automatic void queue_directed_items();
    queue_item(OP_READ,  32'sd0, 4'd0);          // read of an empty store
    queue_item(OP_POP,   32'sd0, 4'd0);          // pop of an empty store
    queue_item(OpUnused, 32'sd5, 4'd3);
    queue_item(OP_PUSH,  32'sd0, 4'd0);          // first push goes to the front
    queue_item(OP_PUSH,  32'sd0, 4'd0);          // tie with the minimum: back
    queue_item(OP_PUSH,  32'sh7fffffff, 4'd0);
    queue_item(OP_PUSH,  32'sh80000000, 4'd0);   // new minimum: front
    queue_item(OP_PUSH,  -32'sd1, 4'd15);        // above the minimum: back
    queue_item(OP_READ,  32'sd0, 4'd0);
    queue_item(OP_READ,  32'sd0, 4'd4);
    queue_item(OP_READ,  32'sd0, 4'd5);          // just past the count
    queue_item(OP_READ,  32'sd0, 4'd15);
    queue_item(OpUnused, -32'sd1, 4'd15);
    queue_item(OP_POP,   32'sd0, 4'd0);
    queue_item(OP_POP,   32'sd0, 4'd0);
    queue_item(OP_POP,   32'sd0, 4'd0);
    queue_item(OP_POP,   32'sd0, 4'd0);
    queue_item(OP_POP,   32'sd0, 4'd0);          // pop of the last element
    queue_item(OP_READ,  32'sd0, 4'd0);
    queue_item(OP_PUSH,  32'sh80000000, 4'd0);
    queue_item(OP_PUSH,  32'sh80000000, 4'd0);   // tie at the most negative value
    queue_item(OP_READ,  32'sd0, 4'd1);
  endfunction

  // -------------------------------------------------------------------- driver
  // input item sampled at the rising edge, next one presented at the falling edge
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall_o) begin
      apply_deque_op(in_item);
      items_taken++;
      in_moved = 1'b1;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_moved)) begin
      in_moved = 1'b0;
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item  <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ------------------------------------------------------------------- monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall) begin
      results_seen++;
      status_seen[out_item_o.status]++;
      if (awaited_results.size() == 0) begin
        $display("[%0t] result item with nothing outstanding", $realtime);
        errors++;
      end else begin
        out_item_t want;
        want = awaited_results.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", out_item_o.status, want.status);
        if (out_item_o.data !== want.data)
          report_mismatch("data", out_item_o.data, want.data);
        if (out_item_o.data_valid !== want.data_valid)
          report_mismatch("data_valid", out_item_o.data_valid, want.data_valid);
        if (out_item_o.count !== want.count)
          report_mismatch("count", out_item_o.count, want.count);
        if (out_item_o.minimum !== want.minimum)
          report_mismatch("minimum", out_item_o.minimum, want.minimum);
      end
    end
  end

  // ------------------------------------------------------------------ watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequencing
  initial begin
    int idle_pct [NumPhases];
    int stall_pct [NumPhases];
    idle_pct  = '{0, 48, 0, 6};
    stall_pct = '{0, 0, 48, 6};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = idle_pct[p];
      recv_stall_pct = stall_pct[p];
      if (p == 0) begin
        queue_directed_items();
        queue_random_items(90);
      end else begin
        queue_random_items(112);
      end
      while (pending_items.size() != 0 || in_valid || awaited_results.size() != 0)
        @(posedge clk_i);
    end

    repeat (DrainWait) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $display("%0d expected result items never arrived", awaited_results.size());
      errors++;
    end

    $display("%0d items through four idling phases, peak fill %0d of %0d",
             items_taken, peak_fill, Depth);
    $display("results: %0d ok, %0d empty, %0d full drops, %0d out of range; %0d mismatches",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_FULL],
             status_seen[ST_RANGE], errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
